### src/keyed_object_store_macros.svh
// Assertion macros for the keyed object store design.
`ifndef KEYED_OBJECT_STORE_MACROS_SVH
`define KEYED_OBJECT_STORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KOS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must never be true.
`define KOS_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

### src/kos_pkg.sv
// Types and constants of the keyed object store.
package kos_pkg;

	localparam int KEY_W  = 64;
	localparam int LEN_W  = 11;
	localparam int BYTE_W = 8;

	// Operation codes carried on the input tuser.
	typedef enum logic [1:0] {
		OP_STORE  = 2'd0,
		OP_FETCH  = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NOP    = 2'd3
	} kos_op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_OFFSET  = 2'd1,
		ST_NOT_FOUND   = 2'd2,
		ST_NO_SPACE    = 2'd3
	} kos_status_t;

endpackage

### src/kos_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module kos_ram
	import kos_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### src/keyed_object_store.sv
// Throughput: one item per cycle while the result side does not stall; the key
// match, entry update and object memory access all finish in the single stage
// between the input and result registers. A store run moves at most one byte
// per item; only its last item returns a result. Reset clears the entry valid
// bits and the run state at once; the object memory is not cleared, since only
// bytes already written can be fetched.
`include "keyed_object_store_macros.svh"

module keyed_object_store
	import kos_pkg::*;
#(
	parameter int SLOTS      = 8,
	parameter int MAX_OBJECT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// tdata: key[63:0], offset[74:64], length[85:75], data_byte[93:86], zero pad
	input  logic [95:0] s_axis_tdata,
	// tuser: opcode[1:0]
	input  logic [1:0]  s_axis_tuser,
	input  logic        s_axis_tlast,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: status[1:0], read_byte[9:2], count[20:10], object_size[31:21]
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int POS_W  = (MAX_OBJECT > 1) ? $clog2(MAX_OBJECT) : 1;
	localparam int DEPTH  = SLOTS * (1 << POS_W);
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Input register.
	logic              valid_s1;
	kos_op_t           op_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [LEN_W-1:0]  offset_s1;
	logic [LEN_W-1:0]  length_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// Result register.
	logic              valid_s2;
	kos_status_t       status_s2;
	logic              byte_s2;
	logic [LEN_W-1:0]  count_s2;
	logic [LEN_W-1:0]  size_s2;

	// Entry table.
	logic [SLOTS-1:0]  entry_valid_q;
	logic [KEY_W-1:0]  entry_key_q  [SLOTS];
	logic [LEN_W-1:0]  entry_size_q [SLOTS];

	// Store run state.
	logic              run_active_q;
	logic              run_fail_q;
	logic [SLOT_W-1:0] run_slot_q;
	logic [LEN_W-1:0]  run_pos_q;
	logic [LEN_W-1:0]  run_len_q;

	// Stage logic.
	logic              advance;
	logic              produces;
	logic              is_store;
	logic              is_fetch;
	logic              is_remove;
	logic [SLOTS-1:0]  hit_vec;
	logic              hit;
	logic [SLOT_W-1:0] hit_idx;
	logic              any_free;
	logic [SLOT_W-1:0] free_idx;
	logic              new_run;
	logic              too_long;
	logic              claim_ok;
	logic [SLOT_W-1:0] claim_idx;
	logic              eff_fail;
	logic [SLOT_W-1:0] eff_slot;
	logic [LEN_W-1:0]  eff_pos;
	logic [LEN_W-1:0]  eff_len;
	logic [LEN_W-1:0]  pos_inc;
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_wr_addr;
	logic [ADDR_W-1:0] ram_rd_addr;
	logic [BYTE_W-1:0] ram_rd_data;
	logic [LEN_W-1:0]  hit_size;
	logic              off_bad;
	logic [LEN_W-1:0]  avail;
	logic [LEN_W-1:0]  fetch_cnt;
	kos_status_t       status_d;
	logic [LEN_W-1:0]  count_d;
	logic [LEN_W-1:0]  size_d;
	logic              dup_key;

	// Key match and free slot search, lowest index wins.
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			hit_vec[i] = entry_valid_q[i] && (entry_key_q[i] == key_s1);
		end
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = SLOT_W'(i);
			end
			if (!entry_valid_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
		hit      = |hit_vec;
		any_free = ~&entry_valid_q;
	end

	// Store run control: the first item of a run claims a slot.
	always_comb begin
		is_store  = valid_s1 && (op_s1 == OP_STORE);
		is_fetch  = valid_s1 && (op_s1 == OP_FETCH);
		is_remove = valid_s1 && (op_s1 == OP_REMOVE);
		new_run   = is_store && !run_active_q;
		too_long  = 32'(length_s1) > 32'(MAX_OBJECT);
		claim_ok  = !too_long && (hit || any_free);
		claim_idx = hit ? hit_idx : free_idx;
		eff_fail  = new_run ? !claim_ok : run_fail_q;
		eff_slot  = new_run ? (claim_ok ? claim_idx : '0) : run_slot_q;
		eff_pos   = new_run ? '0 : run_pos_q;
		eff_len   = new_run ? length_s1 : run_len_q;
		pos_inc   = eff_pos + LEN_W'(1);
		ram_we    = advance && is_store && !eff_fail && (eff_pos < eff_len)
			&& (32'(eff_pos) < 32'(MAX_OBJECT));
		ram_wr_addr = ADDR_W'({eff_slot, POS_W'(eff_pos)});
	end

	// Fetch and remove results.
	always_comb begin
		hit_size  = entry_size_q[hit_idx];
		off_bad   = offset_s1 > hit_size;
		avail     = hit_size - offset_s1;
		fetch_cnt = (length_s1 < avail) ? length_s1 : avail;
		ram_re    = advance && is_fetch && hit && (offset_s1 < hit_size)
			&& (32'(offset_s1) < 32'(MAX_OBJECT));
		ram_rd_addr = ADDR_W'({hit_idx, POS_W'(offset_s1)});
		status_d  = ST_OK;
		count_d   = '0;
		size_d    = '0;
		if (is_store) begin
			status_d = eff_fail ? ST_NO_SPACE : ST_OK;
		end else if (!hit) begin
			status_d = ST_NOT_FOUND;
		end else if (is_fetch) begin
			size_d = hit_size;
			if (off_bad) begin
				status_d = ST_BAD_OFFSET;
			end else begin
				count_d = fetch_cnt;
			end
		end
	end

	// Handshake: the stage moves on when its item has no result or the
	// result register is free or being emptied.
	always_comb begin
		produces      = is_store ? last_s1 : (is_fetch || is_remove);
		advance       = valid_s1 && (!produces || !valid_s2 || m_axis_tready);
		s_axis_tready = !valid_s1 || advance;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1     <= kos_op_t'(s_axis_tuser);
			key_s1    <= s_axis_tdata[63:0];
			offset_s1 <= s_axis_tdata[74:64];
			length_s1 <= s_axis_tdata[85:75];
			byte_s1   <= s_axis_tdata[93:86];
			last_s1   <= s_axis_tlast;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && produces) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produces) begin
			status_s2 <= status_d;
			byte_s2   <= ram_re;
			count_s2  <= count_d;
			size_s2   <= size_d;
		end
	end

	// Valid bits and run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			run_active_q  <= 1'b0;
			run_fail_q    <= 1'b0;
			run_slot_q    <= '0;
			run_pos_q     <= '0;
			run_len_q     <= '0;
		end else if (advance) begin
			if (is_store) begin
				if (new_run && claim_ok) begin
					entry_valid_q[claim_idx] <= 1'b1;
				end
				run_active_q <= !last_s1;
				run_fail_q   <= eff_fail;
				run_slot_q   <= eff_slot;
				run_pos_q    <= ram_we ? pos_inc : eff_pos;
				run_len_q    <= eff_len;
			end else if (is_fetch || is_remove) begin
				run_active_q <= 1'b0;
				if (is_remove && hit) begin
					entry_valid_q[hit_idx] <= 1'b0;
				end
			end
		end
	end

	// Entry keys and sizes; only read behind a valid bit.
	always_ff @(posedge clk) begin
		if (advance && new_run && claim_ok) begin
			entry_key_q[claim_idx] <= key_s1;
		end
		if (ram_we) begin
			entry_size_q[eff_slot] <= pos_inc;
		end else if (advance && new_run && claim_ok) begin
			entry_size_q[claim_idx] <= '0;
		end
	end

	// Object bytes, one region of 2**POS_W bytes per slot.
	kos_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_obj_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (byte_s1),
		.rd_en   (ram_re),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {size_s2, count_s2, (byte_s2 ? ram_rd_data : BYTE_W'(0)),
		status_s2};

	// Two valid entries never share a key.
	always_comb begin
		dup_key = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			for (int j = i + 1; j < SLOTS; j++) begin
				if (entry_valid_q[i] && entry_valid_q[j]
					&& (entry_key_q[i] == entry_key_q[j])) begin
					dup_key = 1'b1;
				end
			end
		end
	end

	`KOS_ASSERT_NEVER(a_unique_keys, dup_key, "two valid entries hold the same key")
	`KOS_ASSERT_IMPL(a_run_slot_valid, run_active_q && !run_fail_q, entry_valid_q[run_slot_q], "run slot free")
	`KOS_ASSERT_IMPL(a_run_pos_bound, run_active_q, run_pos_q <= run_len_q, "run position too far")
	`KOS_ASSERT_IMPL(a_count_bound, valid_s2, count_s2 <= size_s2, "count exceeds the size")
	`KOS_ASSERT_IMPL(a_byte_only_ok, valid_s2 && byte_s2, status_s2 == ST_OK, "byte with an error")

endmodule

### tb/tb.sv
// Self-checking testbench for the keyed object store: streams store, fetch and remove items.
`timescale 1ns / 1ps

module tb;
	import kos_pkg::*;

	// One input item, with its fields unpacked from the stream bus.
	typedef struct {
		kos_op_t     op;
		logic [63:0] key;
		logic [10:0] offset;
		logic [10:0] length;
		logic [7:0]  data_byte;
		logic        last;
	} store_item_t;

	// One result item as it appears on the master side.
	typedef struct {
		kos_status_t status;
		logic [7:0]  read_byte;
		logic [10:0] count;
		logic [10:0] object_size;
	} store_result_t;

	// Tracks the table contents and queues the result each accepted item should produce.
	class object_store_scoreboard;
		localparam int SLOTS      = 8;
		localparam int MAX_OBJECT = 1024;

		bit            used [SLOTS];
		logic [63:0]   keys [SLOTS];
		int            sizes [SLOTS];
		logic [7:0]    obj_mem [SLOTS][MAX_OBJECT];
		bit            run_open;
		int            run_slot;
		int            run_pos;
		int            run_len;
		kos_status_t   run_err;
		store_result_t pending [$];
		int            failures;

		function new();
			foreach (used[i]) begin
				used[i] = 1'b0;
				keys[i] = '0;
				sizes[i] = 0;
			end
			run_open = 1'b0;
			run_slot = 0;
			run_pos = 0;
			run_len = 0;
			run_err = ST_OK;
			failures = 0;
		endfunction

		// Lowest-indexed live entry holding the key, or -1.
		function int find_key(logic [63:0] k);
			for (int i = 0; i < SLOTS; i++)
				if (used[i] && keys[i] == k)
					return i;
			return -1;
		endfunction

		function int first_free();
			for (int i = 0; i < SLOTS; i++)
				if (!used[i])
					return i;
			return -1;
		endfunction

		// Apply one accepted item to the table and queue its result, if it has one.
		function void note_item(store_item_t it);
			store_result_t r;
			int idx;
			int avail;
			r.status = ST_OK;
			r.read_byte = '0;
			r.count = '0;
			r.object_size = '0;
			if (it.op == OP_NOP)
				return;
			if (it.op == OP_STORE) begin
				// The first item of a run picks the slot; every item may carry one byte.
				if (!run_open) begin
					run_pos = 0;
					run_err = ST_OK;
					run_len = it.length;
					run_slot = 0;
					if (it.length > MAX_OBJECT) begin
						run_err = ST_NO_SPACE;
					end else begin
						idx = find_key(it.key);
						if (idx < 0)
							idx = first_free();
						if (idx < 0) begin
							run_err = ST_NO_SPACE;
						end else begin
							run_slot = idx;
							used[idx] = 1'b1;
							keys[idx] = it.key;
							sizes[idx] = 0;
						end
					end
					run_open = 1'b1;
				end
				if (run_err == ST_OK && run_pos < run_len && run_pos < MAX_OBJECT) begin
					obj_mem[run_slot][run_pos] = it.data_byte;
					run_pos++;
					sizes[run_slot] = run_pos;
				end
				if (it.last) begin
					r.status = run_err;
					pending.push_back(r);
					run_open = 1'b0;
				end
				return;
			end
			// A fetch or a remove cuts off any open store run.
			run_open = 1'b0;
			idx = find_key(it.key);
			if (idx < 0) begin
				r.status = ST_NOT_FOUND;
			end else if (it.op == OP_FETCH) begin
				r.object_size = 11'(sizes[idx]);
				if (it.offset > sizes[idx]) begin
					r.status = ST_BAD_OFFSET;
				end else begin
					avail = sizes[idx] - it.offset;
					r.count = 11'((it.length > avail) ? avail : it.length);
					if (it.offset < sizes[idx])
						r.read_byte = obj_mem[idx][it.offset];
				end
			end else begin
				used[idx] = 1'b0;
				keys[idx] = '0;
				sizes[idx] = 0;
			end
			pending.push_back(r);
		endfunction

		// Compare one result transfer with the oldest expectation.
		function void check_result(store_result_t act);
			store_result_t exp;
			if (pending.size() == 0) begin
				$error("unexpected result: status %0d", act.status);
				failures++;
				return;
			end
			exp = pending.pop_front();
			if (act.status !== exp.status) begin
				$error("status: expected %0d, actual %0d", exp.status, act.status);
				failures++;
			end
			if (act.read_byte !== exp.read_byte) begin
				$error("read_byte: expected %0d, actual %0d", exp.read_byte, act.read_byte);
				failures++;
			end
			if (act.count !== exp.count) begin
				$error("count: expected %0d, actual %0d", exp.count, act.count);
				failures++;
			end
			if (act.object_size !== exp.object_size) begin
				$error("object_size: expected %0d, actual %0d", exp.object_size,
					act.object_size);
				failures++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [95:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        s_axis_tlast = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;

	object_store_scoreboard board = new();
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          sent_items = 0;
	logic [63:0] key_pool [12];

	keyed_object_store DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Random backpressure on the result side.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Every input transfer updates the prediction.
	always @(posedge clk) begin
		store_item_t it;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			it.key = s_axis_tdata[63:0];
			it.offset = s_axis_tdata[74:64];
			it.length = s_axis_tdata[85:75];
			it.data_byte = s_axis_tdata[93:86];
			it.op = kos_op_t'(s_axis_tuser);
			it.last = s_axis_tlast;
			board.note_item(it);
		end
	end

	// Every result transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		store_result_t act;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			act.status = kos_status_t'(m_axis_tdata[1:0]);
			act.read_byte = m_axis_tdata[9:2];
			act.count = m_axis_tdata[20:10];
			act.object_size = m_axis_tdata[31:21];
			board.check_result(act);
		end
	end

	// Present one item, with random idle cycles ahead of it, and wait for its transfer.
	task automatic send_item(kos_op_t op, logic [63:0] key, logic [10:0] offset,
		logic [10:0] length, logic [7:0] data_byte, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, data_byte, length, offset, key};
		s_axis_tuser <= op;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (op != OP_NOP)
			sent_items++;
	endtask

	// A store run of n items; only the first carries the length that counts.
	task automatic store_run(logic [63:0] key, int len, int n, bit close);
		for (int i = 0; i < n; i++)
			send_item(OP_STORE, key, 11'($urandom), (i == 0) ? 11'(len) : 11'($urandom),
				8'($urandom), close && (i == n - 1));
	endtask

	task automatic fetch_obj(logic [63:0] key, int offset, int len);
		send_item(OP_FETCH, key, 11'(offset), 11'(len), 8'($urandom), 1'($urandom));
	endtask

	task automatic remove_obj(logic [63:0] key);
		send_item(OP_REMOVE, key, 11'($urandom), 11'($urandom), 8'($urandom),
			1'($urandom));
	endtask

	// Short directed pass over the special cases.
	task automatic run_directed();
		fetch_obj(key_pool[2], 0, 0);
		remove_obj(key_pool[2]);
		send_item(OP_NOP, key_pool[3], 11'h7FF, 11'h7FF, 8'hFF, 1'b1);
		// Zero-length store, then fetches at and past its size.
		store_run(key_pool[0], 0, 1, 1);
		fetch_obj(key_pool[0], 0, 5);
		fetch_obj(key_pool[0], 1, 5);
		store_run(key_pool[1], 3, 3, 1);
		fetch_obj(key_pool[1], 2, 2047);
		// Oversized length is refused.
		store_run(key_pool[2], 2047, 2, 1);
		// Surplus bytes are dropped; an early last keeps what arrived.
		store_run(key_pool[3], 1, 3, 1);
		store_run(key_pool[4], 5, 2, 1);
		// A run cut short by a fetch keeps its partial bytes.
		store_run(key_pool[5], 4, 2, 0);
		fetch_obj(key_pool[5], 1, 3);
		fetch_obj(key_pool[5], 1024, 3);
		// Fill the table, then a new key finds no room.
		store_run(key_pool[6], 0, 1, 1);
		store_run(key_pool[7], 0, 1, 1);
		store_run(key_pool[8], 0, 1, 1);
		store_run(key_pool[9], 0, 1, 1);
		remove_obj(key_pool[3]);
		fetch_obj(key_pool[3], 0, 1);
	endtask

	// Longest accepted length, ended early; reads at its last byte, just past it and at
	// the limit; then a length one above the limit is refused.
	task automatic run_full_object();
		remove_obj(key_pool[10]);
		store_run(key_pool[10], 1024, 40, 1);
		fetch_obj(key_pool[10], 39, 2047);
		fetch_obj(key_pool[10], 40, 1);
		fetch_obj(key_pool[10], 1024, 1);
		store_run(key_pool[11], 1025, 1, 1);
	endtask

	// One random sequence: mostly well-formed runs, fetches and removes, some noise.
	task automatic run_random_sequence();
		logic [63:0] k;
		int pick;
		int len;
		int offset;
		k = ($urandom_range(19) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(11)];
		pick = $urandom_range(99);
		if (pick < 45) begin
			len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
			store_run(k, len, (len == 0) ? 1 : len, 1);
		end else if (pick < 52) begin
			len = $urandom_range(0, 4);
			store_run(k, len, len + $urandom_range(1, 3), 1);
		end else if (pick < 58) begin
			len = $urandom_range(2, 12);
			store_run(k, len, $urandom_range(1, len - 1), 1);
		end else if (pick < 62) begin
			store_run(k, $urandom_range(1025, 2047), $urandom_range(1, 3), 1);
		end else if (pick < 66) begin
			len = $urandom_range(2, 10);
			store_run(k, len, $urandom_range(1, len - 1), 0);
			fetch_obj(k, $urandom_range(0, len), $urandom_range(2047));
		end else if (pick < 86) begin
			case ($urandom_range(9))
				0: offset = 1024;
				1: offset = $urandom_range(0, 1024);
				default: offset = $urandom_range(0, 14);
			endcase
			fetch_obj(k, offset, $urandom_range(2047));
		end else if (pick < 96) begin
			remove_obj(k);
		end else begin
			send_item(kos_op_t'($urandom_range(3)), k, 11'($urandom), 11'($urandom),
				8'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		int goal;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 12; i++)
			key_pool[i] = {$urandom, $urandom};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 11;
					recv_stall_pct = 51;
				end
				1: begin
					send_idle_pct = 51;
					recv_stall_pct = 11;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			if (phase == 0)
				run_directed();
			if (phase == 2)
				run_full_object();
			goal = sent_items + 245;
			while (sent_items < goal)
				run_random_sequence();
		end
		s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (board.failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Hang guard, far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
